[hw/rtl/qrs_pkg.sv]
`default_nettype none
package qrs_pkg;

  // Coefficient format
  localparam int CoefW  = 32;
  localparam int FracW  = 16;
  localparam int MagW   = CoefW;
  localparam int ProdW  = 2 * MagW;
  localparam int DiscW  = 2 * MagW + 1;
  // Square root pipeline
  localparam int RootW  = (DiscW + 1) / 2;
  localparam int SqPadW = 2 * RootW;
  localparam int SqRemW = RootW + 3;
  // Divide pipeline
  localparam int NumW   = RootW + 2;
  localparam int NMagW  = RootW + 1;
  localparam int DvdW   = NMagW + FracW;
  localparam int DvsW   = MagW + 1;
  localparam int DRemW  = DvsW + 1;

  typedef enum logic [1:0] {
    ST_DISTINCT = 2'd0,
    ST_EQUAL    = 2'd1,
    ST_IMAG     = 2'd2,
    ST_DEGEN    = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_b;
    logic signed [CoefW-1:0] coef_c;
  } in_t;

  typedef struct packed {
    logic signed [CoefW-1:0] root_plus;
    logic signed [CoefW-1:0] root_minus;
    status_e                 status;
    logic                    saturated;
  } out_t;

  // Values carried alongside the discriminant and root
  typedef struct packed {
    status_e         status;
    logic            an;
    logic [MagW-1:0] am;
    logic            bn;
    logic [MagW-1:0] bm;
  } side_t;

endpackage
`default_nettype wire

[hw/rtl/qrs_disc.sv]
`default_nettype none
module qrs_disc (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire qrs_pkg::in_t                  data_i,
  output logic                               valid_o,
  output logic [qrs_pkg::DiscW-1:0]          disc_o,
  output qrs_pkg::side_t                     side_o
);

  localparam int MW = qrs_pkg::MagW;
  localparam int PW = qrs_pkg::ProdW;

  logic [2:0] vld_q;

  logic          an1_q, bn1_q, cn1_q;
  logic [MW-1:0] am1_q, bm1_q, cm1_q;
  logic          an2_q, bn2_q, cn2_q;
  logic [MW-1:0] am2_q, bm2_q;
  logic [PW-1:0] bb2_q, ac2_q;
  logic [qrs_pkg::DiscW-1:0] disc_q;
  qrs_pkg::side_t            side_q;

  logic [PW+1:0] bbx, ac4, sum, dif;
  logic [qrs_pkg::DiscW-1:0] disc_d;
  qrs_pkg::side_t            side_d;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // Split signs and magnitudes, then square and cross products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      an1_q <= data_i.coef_a[MW-1];
      bn1_q <= data_i.coef_b[MW-1];
      cn1_q <= data_i.coef_c[MW-1];
      am1_q <= data_i.coef_a[MW-1] ? MW'(-data_i.coef_a) : MW'(data_i.coef_a);
      bm1_q <= data_i.coef_b[MW-1] ? MW'(-data_i.coef_b) : MW'(data_i.coef_b);
      cm1_q <= data_i.coef_c[MW-1] ? MW'(-data_i.coef_c) : MW'(data_i.coef_c);
      an2_q <= an1_q;
      bn2_q <= bn1_q;
      cn2_q <= cn1_q;
      am2_q <= am1_q;
      bm2_q <= bm1_q;
      bb2_q <= bm1_q * bm1_q;
      ac2_q <= am1_q * cm1_q;
      disc_q <= disc_d;
      side_q <= side_d;
    end
  end

  // Form the discriminant and classify
  always_comb begin
    bbx = {2'b00, bb2_q};
    ac4 = {ac2_q, 2'b00};
    sum = bbx + ac4;
    dif = bbx - ac4;
    disc_d = (an2_q != cn2_q) ? sum[qrs_pkg::DiscW-1:0] : dif[qrs_pkg::DiscW-1:0];
    side_d.an = an2_q;
    side_d.am = am2_q;
    side_d.bn = bn2_q;
    side_d.bm = bm2_q;
    if (am2_q == '0) begin
      side_d.status = qrs_pkg::ST_DEGEN;
    end else if ((an2_q == cn2_q) && (bbx < ac4)) begin
      side_d.status = qrs_pkg::ST_IMAG;
    end else if (disc_d == '0) begin
      side_d.status = qrs_pkg::ST_EQUAL;
    end else begin
      side_d.status = qrs_pkg::ST_DISTINCT;
    end
  end

  assign valid_o = vld_q[2];
  assign disc_o  = disc_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

[hw/rtl/qrs_sqrt.sv]
`default_nettype none
module qrs_sqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [qrs_pkg::DiscW-1:0]     disc_i,
  input  wire qrs_pkg::side_t                side_i,
  output logic                               valid_o,
  output logic [qrs_pkg::RootW-1:0]          root_o,
  output qrs_pkg::side_t                     side_o
);

  localparam int RW = qrs_pkg::RootW;
  localparam int XW = qrs_pkg::SqRemW;
  localparam int PW = qrs_pkg::SqPadW;

  typedef struct packed {
    logic [XW-1:0]  rem;
    logic [RW-1:0]  root;
    logic [PW-1:0]  dsh;
    qrs_pkg::side_t side;
  } sq_t;

  // One root bit per stage
  function automatic sq_t sq_step(sq_t s);
    sq_t           r;
    logic [XW-1:0] rem_n;
    logic [XW-1:0] trial;
    rem_n = {s.rem[XW-3:0], s.dsh[PW-1 -: 2]};
    trial = XW'({s.root, 2'b01});
    r     = s;
    r.dsh = {s.dsh[PW-3:0], 2'b00};
    if (rem_n >= trial) begin
      r.rem  = rem_n - trial;
      r.root = {s.root[RW-2:0], 1'b1};
    end else begin
      r.rem  = rem_n;
      r.root = {s.root[RW-2:0], 1'b0};
    end
    return r;
  endfunction

  sq_t           stg_in;
  sq_t           src   [RW];
  sq_t           stg_q [RW];
  logic [RW-1:0] vld_q;

  always_comb begin
    stg_in.rem  = '0;
    stg_in.root = '0;
    stg_in.dsh  = PW'(disc_i);
    stg_in.side = side_i;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RW-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign src[k] = stg_in;
    end else begin : g_next
      assign src[k] = stg_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k] <= sq_step(src[k]);
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = stg_q[RW-1].root;
  assign side_o  = stg_q[RW-1].side;

endmodule
`default_nettype wire

[hw/rtl/qrs_div.sv]
`default_nettype none
module qrs_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [qrs_pkg::RootW-1:0]     root_i,
  input  wire qrs_pkg::side_t                side_i,
  output logic                               valid_o,
  output qrs_pkg::out_t                      data_o
);

  localparam int CW = qrs_pkg::CoefW;
  localparam int NW = qrs_pkg::NumW;
  localparam int MW = qrs_pkg::NMagW;
  localparam int DW = qrs_pkg::DvdW;
  localparam int SW = qrs_pkg::DvsW;
  localparam int RW = qrs_pkg::DRemW;
  localparam int NStg = DW + 2;

  typedef struct packed {
    logic          neg;
    logic [RW-1:0] rem;
    logic [DW-1:0] dvd;
  } lane_t;

  typedef struct packed {
    qrs_pkg::status_e status;
    logic [SW-1:0]    dvs;
    lane_t            lp;
    lane_t            lm;
  } dv_t;

  // One quotient bit per stage; quotient shifts into the dividend
  function automatic lane_t dv_lane(lane_t l, logic [SW-1:0] dvs);
    lane_t         r;
    logic [RW-1:0] rem_n;
    rem_n = {l.rem[RW-2:0], l.dvd[DW-1]};
    r     = l;
    if (rem_n >= RW'(dvs)) begin
      r.rem = rem_n - RW'(dvs);
      r.dvd = {l.dvd[DW-2:0], 1'b1};
    end else begin
      r.rem = rem_n;
      r.dvd = {l.dvd[DW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic lane_t prep_lane(logic signed [NW-1:0] n, logic an);
    lane_t         r;
    logic [NW-1:0] mag;
    mag   = n[NW-1] ? NW'(-n) : NW'(n);
    r.neg = n[NW-1] ^ an;
    r.rem = '0;
    r.dvd = {mag[MW-1:0], {qrs_pkg::FracW{1'b0}}};
    return r;
  endfunction

  // Clip a quotient to the coefficient range
  function automatic logic [CW:0] sat_lane(lane_t l);
    logic [CW-1:0] limit;
    logic [CW-1:0] mag;
    logic          sat;
    limit = l.neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    sat   = (l.dvd[DW-1:CW] != '0) || (l.dvd[CW-1:0] > limit);
    mag   = sat ? limit : l.dvd[CW-1:0];
    return {sat, l.neg ? CW'(-mag) : mag};
  endfunction

  logic signed [NW-1:0] nb, np, nm;
  dv_t                  prep_d;
  dv_t                  prep_q;
  dv_t                  src   [DW];
  dv_t                  stg_q [DW];
  logic [NStg-1:0]      vld_q;
  logic [CW:0]          rp, rm;
  qrs_pkg::out_t        out_d, out_q;

  // Form both numerators and the divisor
  always_comb begin
    nb = side_i.bn ? NW'(side_i.bm) : -NW'(side_i.bm);
    np = nb + NW'(root_i);
    nm = nb - NW'(root_i);
    prep_d.status = side_i.status;
    prep_d.dvs    = {side_i.am, 1'b0};
    prep_d.lp     = prep_lane(np, side_i.an);
    prep_d.lm     = prep_lane(nm, side_i.an);
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NStg-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q <= prep_d;
      out_q  <= out_d;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign src[k] = prep_q;
    end else begin : g_next
      assign src[k] = stg_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k].status <= src[k].status;
        stg_q[k].dvs    <= src[k].dvs;
        stg_q[k].lp     <= dv_lane(src[k].lp, src[k].dvs);
        stg_q[k].lm     <= dv_lane(src[k].lm, src[k].dvs);
      end
    end
  end

  // Saturate and mask roots for the no-root cases
  always_comb begin
    rp = sat_lane(stg_q[DW-1].lp);
    rm = sat_lane(stg_q[DW-1].lm);
    out_d.status = stg_q[DW-1].status;
    if ((stg_q[DW-1].status == qrs_pkg::ST_IMAG) ||
        (stg_q[DW-1].status == qrs_pkg::ST_DEGEN)) begin
      out_d.root_plus  = '0;
      out_d.root_minus = '0;
      out_d.saturated  = 1'b0;
    end else begin
      out_d.root_plus  = rp[CW-1:0];
      out_d.root_minus = rm[CW-1:0];
      out_d.saturated  = rp[CW] | rm[CW];
    end
  end

  assign valid_o = vld_q[NStg-1];
  assign data_o  = out_q;

endmodule
`default_nettype wire

[hw/rtl/quadratic_root_solver_unit.sv]
// Quadratic root solver: a*x^2 + b*x + c = 0 on signed Q16.16 coefficients.
// Input channel in_valid_i/in_ready_o carries one request of coef_a, coef_b,
// coef_c; output channel out_valid_o/out_ready_i returns root_plus,
// root_minus, status and saturated for each request, in order.
// Throughput: one request per cycle while the receiver takes results.
// Pipeline, in order from acceptance to out_valid_o: the sign/magnitude,
// product and discriminant registers, 33 square root stages (one root bit
// each), the numerator setup register, 50 divide stages (one quotient bit
// each, both roots in parallel lanes) and the output register.
// Status: 0 distinct roots, 1 equal roots, 2 imaginary, 3 a is zero; roots
// and saturated read zero for status 2 and 3.
// Reset clears every stage valid bit; the pipeline comes out empty.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated. Bubbles still advance
// while no result is waiting.
`default_nettype none
module quadratic_root_solver_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire qrs_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output qrs_pkg::out_t       out_data_o
);

  logic                          en;
  logic                          dsc_valid, sq_valid;
  logic [qrs_pkg::DiscW-1:0]     dsc;
  logic [qrs_pkg::RootW-1:0]     root;
  qrs_pkg::side_t                dsc_side, sq_side;

  // Advance the pipeline unless a result waits on the receiver
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  qrs_disc u_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (dsc_valid),
    .disc_o  (dsc),
    .side_o  (dsc_side)
  );

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dsc_valid),
    .disc_i  (dsc),
    .side_i  (dsc_side),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_side)
  );

  qrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (root),
    .side_i  (sq_side),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule
`default_nettype wire
